// File: rtl/tba_pkg.sv
// Shared types and constants of the tagged block allocator.
`timescale 1ns / 1ps
`default_nettype none
package tba_pkg;

  localparam int ADDR_W    = 48;
  localparam int SIZE_W    = 32;
  localparam int BCNT_W    = 11;
  localparam int MTAG_W    = 5;
  localparam int KEY_W     = 48;
  localparam int WORD_BITS = 64;
  localparam int FRAME_W   = 16;
  localparam int NUMBER_W  = 32;
  localparam int INDEX_W   = 10;
  localparam int PDATA_W   = 64;
  localparam int PADDR_W   = 5;

  localparam logic [1:0] REG_HEAP_BASE   = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;
  localparam logic [1:0] REG_MAX_TAGS    = 2'd3;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    STAT_ALLOC     = 3'd0,
    STAT_NO_SLOT   = 3'd1,
    STAT_NO_BLOCK  = 3'd2,
    STAT_RELEASED  = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LK_RD,
    S_LK_CMP,
    S_REG_CLR,
    S_SC_RD,
    S_SC_CHK,
    S_MUL,
    S_ADDR,
    S_EMIT,
    S_RL_RD,
    S_RL_LAST,
    S_RL_WR,
    S_RL_KRD,
    S_RL_KWR
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] heap_base;
    logic [SIZE_W-1:0] block_size;
    logic [BCNT_W-1:0] block_count;
    logic [MTAG_W-1:0] max_tags;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/tba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/tba_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module tba_regs
  import tba_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[4:3])
        REG_HEAP_BASE:   cfg_d.heap_base   = pwdata[ADDR_W-1:0];
        REG_BLOCK_SIZE:  cfg_d.block_size  = pwdata[SIZE_W-1:0];
        REG_BLOCK_COUNT: cfg_d.block_count = pwdata[BCNT_W-1:0];
        REG_MAX_TAGS:    cfg_d.max_tags    = pwdata[MTAG_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heap_base   <= '0;
      cfg_q.block_size  <= SIZE_W'(65536);
      cfg_q.block_count <= BCNT_W'(1024);
      cfg_q.max_tags    <= MTAG_W'(16);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_HEAP_BASE:   prdata = PDATA_W'(cfg_q.heap_base);
      REG_BLOCK_SIZE:  prdata = PDATA_W'(cfg_q.block_size);
      REG_BLOCK_COUNT: prdata = PDATA_W'(cfg_q.block_count);
      REG_MAX_TAGS:    prdata = PDATA_W'(cfg_q.max_tags);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: rtl/tba_ctrl.sv
// Sequencer and datapath: tag lookup, bitmap scan, release sweep, address math.
`timescale 1ns / 1ps
`default_nettype none
module tba_ctrl
  import tba_pkg::*;
#(
  parameter int NUM_BLOCKS    = 1024,
  parameter int MAX_TAG_SLOTS = 16,
  localparam int MAP_WORDS  = (NUM_BLOCKS + 63) / 64,
  localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
  localparam int SLOT_W     = (MAX_TAG_SLOTS > 1) ? $clog2(MAX_TAG_SLOTS) : 1,
  localparam int MASK_DEPTH = MAX_TAG_SLOTS * MAP_WORDS,
  localparam int MASK_AW    = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic                 kind_i,
  input  wire logic [FRAME_W-1:0]   tag_frame_i,
  input  wire logic [NUMBER_W-1:0]  tag_number_i,
  input  wire cfg_t                 cfg_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic      [2:0]           status_o,
  output logic      [INDEX_W-1:0]   block_index_o,
  output logic      [ADDR_W-1:0]    block_start_o,
  output logic      [ADDR_W-1:0]    block_end_o,
  // bitmap memory
  output logic                      map_we_o,
  output logic      [WORD_W-1:0]    map_waddr_o,
  output logic      [WORD_BITS-1:0] map_wdata_o,
  output logic                      map_re_o,
  output logic      [WORD_W-1:0]    map_raddr_o,
  input  wire logic [WORD_BITS-1:0] map_rdata_i,
  // tag key memory
  output logic                      key_we_o,
  output logic      [SLOT_W-1:0]    key_waddr_o,
  output logic      [KEY_W-1:0]     key_wdata_o,
  output logic                      key_re_o,
  output logic      [SLOT_W-1:0]    key_raddr_o,
  input  wire logic [KEY_W-1:0]     key_rdata_i,
  // tag mask memory
  output logic                      mask_we_o,
  output logic      [MASK_AW-1:0]   mask_waddr_o,
  output logic      [WORD_BITS-1:0] mask_wdata_o,
  output logic                      mask_re_o,
  output logic      [MASK_AW-1:0]   mask_raddr_o,
  input  wire logic [WORD_BITS-1:0] mask_rdata_i
);

  localparam int WCNT_W = $clog2(MAP_WORDS + 1);
  localparam int TCNT_W = $clog2(MAX_TAG_SLOTS + 1);
  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int CMP_W  = (BCNT_W > WCNT_W + 6) ? BCNT_W : WCNT_W + 6;
  localparam int LIM_W  = (MTAG_W > TCNT_W) ? MTAG_W : TCNT_W;
  localparam int ROW_W  = MASK_AW + SLOT_W + 1;
  localparam int PROD_W = IDX_W + SIZE_W;

  function automatic logic [MASK_AW-1:0] mask_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [WORD_W-1:0] word);
    logic [ROW_W-1:0] full;
    full = ROW_W'(slot) * ROW_W'(MAP_WORDS) + ROW_W'(word);
    return full[MASK_AW-1:0];
  endfunction

  state_e state_q, state_d;

  logic                 kind_q;
  logic [KEY_W-1:0]     key_q;
  logic [TCNT_W-1:0]    lk_q, active_q, act_m1;
  logic [SLOT_W-1:0]    slot_q, last_slot;
  logic [WCNT_W-1:0]    w_q;
  logic [WORD_W-1:0]    w_idx;
  logic                 w_last;
  logic [WORD_BITS-1:0] lim_q, lim, avail, lowbit;
  logic [WORD_BITS-1:0] map_hold_q, mslot_hold_q;
  logic [5:0]           bitpos;
  logic [IDX_W-1:0]     idx_q;
  logic [PROD_W-1:0]    prod_q;
  logic [ADDR_W-1:0]    start_q;
  logic [CMP_W-1:0]     cnt_cfg, count_eff, base, rem;
  logic                 no_more, full, lk_end, key_hit;

  logic                 emit;
  status_e              emit_status;
  logic [INDEX_W-1:0]   emit_index;
  logic [ADDR_W-1:0]    emit_start, emit_end;

  logic                 done_q;
  logic [2:0]           status_q;
  logic [INDEX_W-1:0]   index_q;
  logic [ADDR_W-1:0]    bstart_q, bend_q;

  // Shared decode of counters and limits
  assign w_idx     = w_q[WORD_W-1:0];
  assign w_last    = (w_q == WCNT_W'(MAP_WORDS - 1));
  assign act_m1    = active_q - TCNT_W'(1);
  assign last_slot = act_m1[SLOT_W-1:0];
  assign lk_end    = (lk_q == active_q);
  assign key_hit   = (key_rdata_i == key_q);
  assign full      = (LIM_W'(active_q) >= LIM_W'(cfg_i.max_tags)) ||
                     (active_q >= TCNT_W'(MAX_TAG_SLOTS));

  assign cnt_cfg   = CMP_W'(cfg_i.block_count);
  assign count_eff = (cnt_cfg > CMP_W'(NUM_BLOCKS)) ? CMP_W'(NUM_BLOCKS) : cnt_cfg;
  assign base      = CMP_W'({w_q, 6'b0});
  assign no_more   = (count_eff <= base);
  assign rem       = count_eff - base;
  assign lim       = (rem >= CMP_W'(WORD_BITS)) ? '1 : ~({WORD_BITS{1'b1}} << rem[5:0]);

  assign avail  = ~map_rdata_i & lim_q;
  assign lowbit = avail & (~avail + WORD_BITS'(1));

  always_comb begin
    bitpos = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (lowbit[b]) begin
        bitpos = bitpos | 6'(b);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (w_last) state_d = S_IDLE;
      S_IDLE:    if (start_i) state_d = S_LK_RD;
      S_LK_RD: begin
        if (!lk_end) begin
          state_d = S_LK_CMP;
        end else if (kind_q == KIND_RELEASE || full) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_REG_CLR;
        end
      end
      S_LK_CMP: begin
        if (!key_hit) begin
          state_d = S_LK_RD;
        end else if (kind_q == KIND_RELEASE) begin
          state_d = S_RL_RD;
        end else begin
          state_d = S_SC_RD;
        end
      end
      S_REG_CLR: if (w_last) state_d = S_SC_RD;
      S_SC_RD:   state_d = no_more ? S_IDLE : S_SC_CHK;
      S_SC_CHK:  state_d = (avail != '0) ? S_MUL : S_SC_RD;
      S_MUL:     state_d = S_ADDR;
      S_ADDR:    state_d = S_EMIT;
      S_EMIT:    state_d = S_IDLE;
      S_RL_RD:   state_d = S_RL_LAST;
      S_RL_LAST: state_d = S_RL_WR;
      S_RL_WR:   state_d = w_last ? S_RL_KRD : S_RL_RD;
      S_RL_KRD:  state_d = S_RL_KWR;
      S_RL_KWR:  state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Memory commands and result
  always_comb begin
    map_we_o     = 1'b0;
    map_waddr_o  = w_idx;
    map_wdata_o  = '0;
    map_re_o     = 1'b0;
    map_raddr_o  = w_idx;
    key_we_o     = 1'b0;
    key_waddr_o  = slot_q;
    key_wdata_o  = key_q;
    key_re_o     = 1'b0;
    key_raddr_o  = lk_q[SLOT_W-1:0];
    mask_we_o    = 1'b0;
    mask_waddr_o = mask_addr(slot_q, w_idx);
    mask_wdata_o = '0;
    mask_re_o    = 1'b0;
    mask_raddr_o = mask_addr(slot_q, w_idx);
    emit         = 1'b0;
    emit_status  = STAT_ALLOC;
    emit_index   = '0;
    emit_start   = '0;
    emit_end     = '0;
    case (state_q)
      S_CLEAR: begin
        map_we_o = 1'b1;
      end
      S_LK_RD: begin
        if (!lk_end) begin
          key_re_o = 1'b1;
        end else if (kind_q == KIND_RELEASE) begin
          emit        = 1'b1;
          emit_status = STAT_NOT_FOUND;
        end else if (full) begin
          emit        = 1'b1;
          emit_status = STAT_NO_SLOT;
        end else begin
          key_we_o    = 1'b1;
          key_waddr_o = active_q[SLOT_W-1:0];
        end
      end
      S_REG_CLR: begin
        mask_we_o = 1'b1;
      end
      S_SC_RD: begin
        if (no_more) begin
          emit        = 1'b1;
          emit_status = STAT_NO_BLOCK;
        end else begin
          map_re_o  = 1'b1;
          mask_re_o = 1'b1;
        end
      end
      S_SC_CHK: begin
        if (avail != '0) begin
          map_we_o     = 1'b1;
          map_wdata_o  = map_rdata_i | lowbit;
          mask_we_o    = 1'b1;
          mask_wdata_o = mask_rdata_i | lowbit;
        end
      end
      S_EMIT: begin
        emit        = 1'b1;
        emit_status = STAT_ALLOC;
        emit_index  = INDEX_W'(idx_q);
        emit_start  = start_q;
        emit_end    = start_q + ADDR_W'(cfg_i.block_size);
      end
      S_RL_RD: begin
        map_re_o  = 1'b1;
        mask_re_o = 1'b1;
      end
      S_RL_LAST: begin
        mask_re_o    = 1'b1;
        mask_raddr_o = mask_addr(last_slot, w_idx);
      end
      S_RL_WR: begin
        map_we_o     = 1'b1;
        map_wdata_o  = map_hold_q & ~mslot_hold_q;
        mask_we_o    = 1'b1;
        mask_wdata_o = mask_rdata_i;
      end
      S_RL_KRD: begin
        key_re_o    = 1'b1;
        key_raddr_o = last_slot;
      end
      S_RL_KWR: begin
        key_we_o    = 1'b1;
        key_wdata_o = key_rdata_i;
        emit        = 1'b1;
        emit_status = STAT_RELEASED;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      active_q <= '0;
      w_q      <= '0;
      lk_q     <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= emit;
      case (state_q)
        S_CLEAR, S_REG_CLR: w_q <= w_last ? '0 : w_q + WCNT_W'(1);
        S_IDLE:   lk_q <= '0;
        S_LK_RD: begin
          if (lk_end && kind_q == KIND_REQUEST && !full) begin
            active_q <= active_q + TCNT_W'(1);
            w_q      <= '0;
          end
        end
        S_LK_CMP: begin
          if (key_hit) begin
            w_q <= '0;
          end else begin
            lk_q <= lk_q + TCNT_W'(1);
          end
        end
        S_SC_CHK: if (avail == '0) w_q <= w_q + WCNT_W'(1);
        S_RL_WR:  w_q <= w_q + WCNT_W'(1);
        S_RL_KWR: active_q <= act_m1;
        default:  lk_q <= lk_q;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_q <= kind_i;
          key_q  <= {tag_frame_i, tag_number_i};
        end
      end
      S_LK_RD:   if (lk_end) slot_q <= active_q[SLOT_W-1:0];
      S_LK_CMP:  if (key_hit) slot_q <= lk_q[SLOT_W-1:0];
      S_SC_RD:   lim_q <= lim;
      S_SC_CHK:  idx_q <= IDX_W'({w_idx, bitpos});
      S_MUL:     prod_q <= PROD_W'(idx_q) * PROD_W'(cfg_i.block_size);
      S_ADDR:    start_q <= cfg_i.heap_base + ADDR_W'(prod_q);
      S_RL_LAST: begin
        map_hold_q   <= map_rdata_i;
        mslot_hold_q <= mask_rdata_i;
      end
      default:   start_q <= start_q;
    endcase
    if (emit) begin
      status_q <= emit_status;
      index_q  <= emit_index;
      bstart_q <= emit_start;
      bend_q   <= emit_end;
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign block_index_o = index_q;
  assign block_start_o = bstart_q;
  assign block_end_o   = bend_q;

endmodule
`default_nettype wire

// File: rtl/tagged_block_allocator_unit.sv
// Top level of the tagged block allocator.
`timescale 1ns / 1ps
`default_nettype none
// Fixed-size block allocator with tag ownership. Pulse start while busy is low
// to hand over one request (kind 0) or release (kind 1) for the tag formed by
// tag_frame_i and tag_number_i. Exactly one result follows, shown for one cycle
// with done_o high; it cannot be stalled, so capture it on that cycle. After
// reset the block runs a clearing pass over the MAP_WORDS bitmap words with
// busy high. Steps per item, with W = MAP_WORDS: lookup compares the active
// tags one at a time; a new tag then zeroes its W-word mask row; a request
// then scans the bitmap up to the first word with a free block and does the
// address math (multiply, add, end address); a release sweeps all W words and
// then moves the last key into the freed slot. The scan and the release sweep
// walk one word at a time over the single read port of each memory. The user
// must write configuration registers over the APB-style port only while the
// block is idle; the block itself does not enforce this.
module tagged_block_allocator_unit
  import tba_pkg::*;
#(
  parameter int NUM_BLOCKS    = 1024,
  parameter int MAX_TAG_SLOTS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // command channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                kind_i,
  input  wire logic [FRAME_W-1:0]  tag_frame_i,
  input  wire logic [NUMBER_W-1:0] tag_number_i,
  // result strobe and fields
  output logic                     done_o,
  output logic      [2:0]          status_o,
  output logic      [INDEX_W-1:0]  block_index_o,
  output logic      [ADDR_W-1:0]   block_start_o,
  output logic      [ADDR_W-1:0]   block_end_o,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready
);

  localparam int MAP_WORDS  = (NUM_BLOCKS + 63) / 64;
  localparam int WORD_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SLOT_W     = (MAX_TAG_SLOTS > 1) ? $clog2(MAX_TAG_SLOTS) : 1;
  localparam int MASK_DEPTH = MAX_TAG_SLOTS * MAP_WORDS;
  localparam int MASK_AW    = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;

  cfg_t cfg;

  logic                 map_we, map_re;
  logic [WORD_W-1:0]    map_waddr, map_raddr;
  logic [WORD_BITS-1:0] map_wdata, map_rdata;
  logic                 key_we, key_re;
  logic [SLOT_W-1:0]    key_waddr, key_raddr;
  logic [KEY_W-1:0]     key_wdata, key_rdata;
  logic                 mask_we, mask_re;
  logic [MASK_AW-1:0]   mask_waddr, mask_raddr;
  logic [WORD_BITS-1:0] mask_wdata, mask_rdata;

  // Register file: latch each completed write transfer
  tba_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: owns every memory port and the result registers
  tba_ctrl #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .MAX_TAG_SLOTS (MAX_TAG_SLOTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .kind_i        (kind_i),
    .tag_frame_i   (tag_frame_i),
    .tag_number_i  (tag_number_i),
    .cfg_i         (cfg),
    .busy_o        (busy),
    .done_o        (done_o),
    .status_o      (status_o),
    .block_index_o (block_index_o),
    .block_start_o (block_start_o),
    .block_end_o   (block_end_o),
    .map_we_o      (map_we),
    .map_waddr_o   (map_waddr),
    .map_wdata_o   (map_wdata),
    .map_re_o      (map_re),
    .map_raddr_o   (map_raddr),
    .map_rdata_i   (map_rdata),
    .key_we_o      (key_we),
    .key_waddr_o   (key_waddr),
    .key_wdata_o   (key_wdata),
    .key_re_o      (key_re),
    .key_raddr_o   (key_raddr),
    .key_rdata_i   (key_rdata),
    .mask_we_o     (mask_we),
    .mask_waddr_o  (mask_waddr),
    .mask_wdata_o  (mask_wdata),
    .mask_re_o     (mask_re),
    .mask_raddr_o  (mask_raddr),
    .mask_rdata_i  (mask_rdata)
  );

  // Global bitmap, one 64-bit word per row; cleared by the pass after reset
  tba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  // Tag keys; only slots below the active count are ever read
  tba_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_TAG_SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // Per-tag ownership masks, row = slot * MAP_WORDS + word; zeroed on registration
  tba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MASK_DEPTH)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (mask_we),
    .waddr_i (mask_waddr),
    .wdata_i (mask_wdata),
    .re_i    (mask_re),
    .raddr_i (mask_raddr),
    .rdata_o (mask_rdata)
  );

endmodule
`default_nettype wire

// File: rtl/tba_checker.sv
// Port-level checks of the tagged block allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tba_checker
  import tba_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done_o,
  input wire logic [2:0]         status_o,
  input wire logic [INDEX_W-1:0] block_index_o,
  input wire logic [ADDR_W-1:0]  block_start_o,
  input wire logic [ADDR_W-1:0]  block_end_o
);

  // An accepted transfer keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A result ends a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of a busy period");

  // Only defined status codes come out
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == STAT_ALLOC || status_o == STAT_NO_SLOT ||
                status_o == STAT_NO_BLOCK || status_o == STAT_RELEASED ||
                status_o == STAT_NOT_FOUND))
    else $error("undefined status code");

  // Failed or release results carry zero block fields
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != STAT_ALLOC) |->
      (block_index_o == '0 && block_start_o == '0 && block_end_o == '0))
    else $error("block fields set on a non-allocation result");

endmodule

bind tagged_block_allocator_unit tba_checker u_tba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .block_index_o (block_index_o),
  .block_start_o (block_start_o),
  .block_end_o   (block_end_o)
);
`default_nettype wire

// File: tb/tagged_block_allocator_unit_tb.sv
// Self-checking testbench for the tagged block allocator top level.
`timescale 1ns / 1ps
module tagged_block_allocator_unit_tb;
  import tba_pkg::*;

  localparam int NBLK       = 1024;
  localparam int NSLOT      = 16;
  localparam int CYCLE_CAP  = 2000000;
  localparam int RAND_ITEMS = 1150;
  localparam int DRAIN      = 300;

  typedef struct packed {
    status_e             status;
    logic [INDEX_W-1:0]  index;
    logic [ADDR_W-1:0]   bstart;
    logic [ADDR_W-1:0]   bend;
  } outcome_t;

  typedef struct {
    bit                  is_cfg;
    logic [1:0]          reg_sel;
    logic [63:0]         value;
    logic                kind;
    logic [FRAME_W-1:0]  frame;
    logic [NUMBER_W-1:0] number;
    bit                  typed;
    outcome_t            want;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                kind_i = 1'b0;
  logic [FRAME_W-1:0]  tag_frame_i = '0;
  logic [NUMBER_W-1:0] tag_number_i = '0;
  logic                done_o;
  logic [2:0]          status_o;
  logic [INDEX_W-1:0]  block_index_o;
  logic [ADDR_W-1:0]   block_start_o;
  logic [ADDR_W-1:0]   block_end_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  tagged_block_allocator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .start(start), .busy(busy),
    .kind_i(kind_i), .tag_frame_i(tag_frame_i), .tag_number_i(tag_number_i),
    .done_o(done_o), .status_o(status_o), .block_index_o(block_index_o),
    .block_start_o(block_start_o), .block_end_o(block_end_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the allocator: configuration, bitmap, tag keys and masks.
  logic [ADDR_W-1:0]  sh_base;
  logic [SIZE_W-1:0]  sh_size;
  logic [BCNT_W-1:0]  sh_count;
  logic [MTAG_W-1:0]  sh_tags;
  logic [NBLK-1:0]    sh_map;
  logic [KEY_W-1:0]   sh_keys [NSLOT];
  logic [NBLK-1:0]    sh_masks [NSLOT];
  int                 sh_active;

  outcome_t outcome_q[$];
  row_t     plan[$];
  int       errors = 0;
  int       cycles = 0;
  int       n_items = 0;
  int       n_alloc = 0;
  int       n_release = 0;
  int       n_phases = 0;

  // Apply one item to the shadow state and return what the block must report.
  function automatic outcome_t alloc_step(logic kind, logic [FRAME_W-1:0] frame,
                                          logic [NUMBER_W-1:0] number);
    outcome_t   o;
    logic [KEY_W-1:0] key;
    int         lim;
    int         cnt;
    int         slot;
    int         last;
    bit         found;
    logic [63:0] st;
    o = '{status: STAT_NO_BLOCK, index: '0, bstart: '0, bend: '0};
    key = {frame, number};
    lim = (sh_tags > NSLOT) ? NSLOT : int'(sh_tags);
    cnt = (sh_count > NBLK) ? NBLK : int'(sh_count);
    slot = 0;
    found = 0;
    for (int i = 0; i < sh_active; i++) begin
      if (!found && sh_keys[i] == key) begin
        slot = i;
        found = 1;
      end
    end
    if (kind == KIND_RELEASE) begin
      if (!found) begin
        o.status = STAT_NOT_FOUND;
        return o;
      end
      last = sh_active - 1;
      sh_map &= ~sh_masks[slot];
      sh_masks[slot] = sh_masks[last];
      sh_masks[last] = '0;
      sh_keys[slot] = sh_keys[last];
      sh_keys[last] = '0;
      sh_active = last;
      o.status = STAT_RELEASED;
      return o;
    end
    if (!found) begin
      if (sh_active >= lim) begin
        o.status = STAT_NO_SLOT;
        return o;
      end
      slot = sh_active;
      sh_keys[slot] = key;
      sh_masks[slot] = '0;
      sh_active++;
    end
    for (int b = 0; b < cnt; b++) begin
      if (!sh_map[b]) begin
        sh_map[b] = 1'b1;
        sh_masks[slot][b] = 1'b1;
        st = (64'(sh_base) + 64'(b) * 64'(sh_size)) & 64'hFFFF_FFFF_FFFF;
        o.status = STAT_ALLOC;
        o.index = b[INDEX_W-1:0];
        o.bstart = st[ADDR_W-1:0];
        o.bend = ADDR_W'(st + 64'(sh_size));
        return o;
      end
    end
    return o;
  endfunction

  // Hold until the block is idle and every expected result has been seen.
  task automatic wait_idle();
    do @(negedge clk_i); while (outcome_q.size() != 0 || busy);
  endtask

  // APB write in setup and access phases; the register takes the value at the access edge.
  task automatic write_reg(logic [1:0] sel, logic [63:0] value);
    wait_idle();
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (sel)
      REG_HEAP_BASE:   sh_base = value[ADDR_W-1:0];
      REG_BLOCK_SIZE:  sh_size = value[SIZE_W-1:0];
      REG_BLOCK_COUNT: sh_count = value[BCNT_W-1:0];
      default:         sh_tags = value[MTAG_W-1:0];
    endcase
  endtask

  // Present one item, hold it until the transfer, then drop start.
  task automatic issue(logic kind, logic [FRAME_W-1:0] frame,
                       logic [NUMBER_W-1:0] number, bit typed, outcome_t want);
    outcome_t got;
    @(posedge clk_i);
    start <= 1'b1;
    kind_i <= kind;
    tag_frame_i <= frame;
    tag_number_i <= number;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
      @(posedge clk_i);
    end
    got = alloc_step(kind, frame, number);
    outcome_q.push_back(typed ? want : got);
    n_items++;
    if (kind == KIND_RELEASE) n_release++;
    else n_alloc++;
    @(posedge clk_i);
    start <= 1'b0;
  endtask

  function automatic row_t cfg_row(logic [1:0] sel, logic [63:0] value);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.reg_sel = sel;
    r.value = value;
    return r;
  endfunction

  function automatic row_t item_row(logic kind, logic [FRAME_W-1:0] frame,
                                    logic [NUMBER_W-1:0] number, bit typed,
                                    status_e st, logic [INDEX_W-1:0] idx,
                                    logic [ADDR_W-1:0] bs, logic [ADDR_W-1:0] be);
    row_t r;
    r = '{default: '0};
    r.kind = kind;
    r.frame = frame;
    r.number = number;
    r.typed = typed;
    r.want = '{status: st, index: idx, bstart: bs, bend: be};
    return r;
  endfunction

  // Compare each strobed result against the oldest expectation.
  always @(negedge clk_i) begin
    outcome_t exp_o;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result status %0d", $time, status_o);
        errors++;
      end else begin
        exp_o = outcome_q.pop_front();
        if (status_o !== exp_o.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_o.status, status_o);
          errors++;
        end
        if (block_index_o !== exp_o.index) begin
          $display("%0t: block_index expected %0d actual %0d", $time, exp_o.index,
                   block_index_o);
          errors++;
        end
        if (block_start_o !== exp_o.bstart) begin
          $display("%0t: block_start expected %h actual %h", $time, exp_o.bstart,
                   block_start_o);
          errors++;
        end
        if (block_end_o !== exp_o.bend) begin
          $display("%0t: block_end expected %h actual %h", $time, exp_o.bend, block_end_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] pool [20];
    logic [KEY_W-1:0] k;
    int burst;
    int sent;
    int pick;
    logic kind;

    sh_base = '0;
    sh_size = 32'd65536;
    sh_count = 11'd1024;
    sh_tags = 5'd16;
    sh_map = '0;
    sh_active = 0;
    for (int i = 0; i < NSLOT; i++) begin
      sh_keys[i] = '0;
      sh_masks[i] = '0;
    end

    // Directed walk: defaults, tag churn, refused tags, empty heap,
    // zero block size with wrap, one-block heap, then a full block count at a high base.
    plan.push_back(item_row(KIND_REQUEST, 16'h0, 32'h0, 1, STAT_ALLOC, 0, 0, 48'd65536));
    plan.push_back(item_row(KIND_REQUEST, 16'hFFFF, 32'hFFFF_FFFF, 1, STAT_ALLOC, 1,
                            48'd65536, 48'd131072));
    plan.push_back(item_row(KIND_REQUEST, 16'h0, 32'h0, 1, STAT_ALLOC, 2,
                            48'd131072, 48'd196608));
    plan.push_back(item_row(KIND_RELEASE, 16'h1, 32'h5, 1, STAT_NOT_FOUND, 0, 0, 0));
    plan.push_back(item_row(KIND_RELEASE, 16'h0, 32'h0, 1, STAT_RELEASED, 0, 0, 0));
    plan.push_back(item_row(KIND_REQUEST, 16'hFFFF, 32'hFFFF_FFFF, 1, STAT_ALLOC, 0,
                            0, 48'd65536));
    plan.push_back(cfg_row(REG_MAX_TAGS, 64'd0));
    plan.push_back(item_row(KIND_REQUEST, 16'h12, 32'h34, 1, STAT_NO_SLOT, 0, 0, 0));
    plan.push_back(item_row(KIND_REQUEST, 16'hFFFF, 32'hFFFF_FFFF, 1, STAT_ALLOC, 2,
                            48'd131072, 48'd196608));
    plan.push_back(cfg_row(REG_MAX_TAGS, 64'd31));
    plan.push_back(cfg_row(REG_BLOCK_COUNT, 64'd0));
    plan.push_back(item_row(KIND_REQUEST, 16'h7, 32'h7, 1, STAT_NO_BLOCK, 0, 0, 0));
    plan.push_back(item_row(KIND_RELEASE, 16'h7, 32'h7, 1, STAT_RELEASED, 0, 0, 0));
    plan.push_back(cfg_row(REG_BLOCK_COUNT, 64'd2047));
    plan.push_back(cfg_row(REG_BLOCK_SIZE, 64'd0));
    plan.push_back(cfg_row(REG_HEAP_BASE, 64'hFFFF_FFFF_FFFF));
    plan.push_back(item_row(KIND_REQUEST, 16'hFFFF, 32'hFFFF_FFFF, 1, STAT_ALLOC, 3,
                            48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    plan.push_back(cfg_row(REG_BLOCK_SIZE, 64'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_HEAP_BASE, 64'd0));
    plan.push_back(cfg_row(REG_BLOCK_COUNT, 64'd1));
    plan.push_back(item_row(KIND_REQUEST, 16'h1, 32'h1, 1, STAT_NO_BLOCK, 0, 0, 0));
    plan.push_back(item_row(KIND_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 1, STAT_RELEASED, 0, 0, 0));
    plan.push_back(item_row(KIND_REQUEST, 16'h1, 32'h1, 1, STAT_ALLOC, 0, 0,
                            48'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_HEAP_BASE, 64'hFFFF_FFFF_0000));
    plan.push_back(cfg_row(REG_BLOCK_COUNT, 64'd1024));
    plan.push_back(item_row(KIND_REQUEST, 16'hA5A5, 32'h5A5A_5A5A, 0, STAT_ALLOC, 0, 0, 0));
    plan.push_back(item_row(KIND_REQUEST, 16'hA5A5, 32'h5A5A_5A5A, 0, STAT_ALLOC, 0, 0, 0));
    plan.push_back(item_row(KIND_RELEASE, 16'h1, 32'h1, 0, STAT_ALLOC, 0, 0, 0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_sel, plan[i].value);
      else issue(plan[i].kind, plan[i].frame, plan[i].number, plan[i].typed,
                 plan[i].want);
    end

    // Random phases: new settings, then bursts drawn from a small tag pool
    // so that lookups hit, heaps fill up and releases find their tags.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      n_phases++;
      case ($urandom_range(0, 3))
        0: write_reg(REG_HEAP_BASE, 64'hFFFF_FFFF_FFFF);
        1: write_reg(REG_HEAP_BASE, 64'd0);
        default: write_reg(REG_HEAP_BASE, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(REG_BLOCK_SIZE, 64'd0);
        1: write_reg(REG_BLOCK_SIZE, 64'hFFFF_FFFF);
        2: write_reg(REG_BLOCK_SIZE, 64'($urandom_range(1, 4096)));
        default: write_reg(REG_BLOCK_SIZE, 64'($urandom));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(REG_BLOCK_COUNT, 64'($urandom_range(0, 2047)));
        1: write_reg(REG_BLOCK_COUNT, 64'd1024);
        2: write_reg(REG_BLOCK_COUNT, 64'($urandom_range(60, 140)));
        default: write_reg(REG_BLOCK_COUNT, 64'($urandom_range(0, 24)));
      endcase
      write_reg(REG_MAX_TAGS, 64'($urandom_range(0, 31)));
      for (int i = 0; i < 20; i++) pool[i] = KEY_W'({$urandom, $urandom});
      for (int j = 0; j < 110 && sent < RAND_ITEMS; ) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst; b++) begin
          pick = $urandom_range(0, 99);
          if (pick < 8) k = KEY_W'({$urandom, $urandom});
          else k = pool[$urandom_range(0, (pick < 60) ? 5 : 19)];
          kind = ($urandom_range(0, 99) < 28) ? KIND_RELEASE : KIND_REQUEST;
          issue(kind, k[47:32], k[31:0], 0, outcome_t'(0));
          sent++;
          j++;
        end
        // Skip some bursts' gap entirely so items run back to back.
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end

    wait_idle();
    repeat (DRAIN) @(posedge clk_i);
    $display("Covered %0d items (%0d requests, %0d releases) over %0d random settings.",
             n_items, n_alloc, n_release, n_phases);
    if (outcome_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, outcome_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
